// ----- rtl/gng_pkg.sv -----
// Shared constants, table builders and helper functions of the Gaussian noise generator.
`default_nettype none
package gng_pkg;

  localparam logic [63:0] GOLDEN     = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] PCG_MULT   = 64'd6364136223846793005;
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [31:0] LN2_Q32    = 32'hB17217F8;
  localparam logic [63:0] LCG_RESET  = (64'd1 + GOLDEN) * PCG_MULT + 64'd1;
  localparam logic [63:0] HALFPI_Q30 = (PI_Q60 + (64'd1 << 30)) >> 31;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_ADV0  = 18'h00002,
    ST_ADV1  = 18'h00004,
    ST_ADV2  = 18'h00008,
    ST_ADV3  = 18'h00010,
    ST_NORM  = 18'h00020,
    ST_LN    = 18'h00040,
    ST_LNMUL = 18'h00080,
    ST_LNSUB = 18'h00100,
    ST_SQRT  = 18'h00200,
    ST_ANG   = 18'h00400,
    ST_ANG2  = 18'h00800,
    ST_CORD  = 18'h01000,
    ST_MULC  = 18'h02000,
    ST_MULS  = 18'h04000,
    ST_SINR  = 18'h08000,
    ST_FIN   = 18'h10000,
    ST_SPARE = 18'h20000
  } state_e;

  typedef enum logic [2:0] {
    PH_SEED = 3'b001,
    PH_X1   = 3'b010,
    PH_X2   = 3'b100
  } phase_e;

  // Long division for the table builders; both operands are non-negative.
  function automatic longint div_floor(input longint num, input longint den);
    longint q;
    longint r;
    int i;
    q = 0;
    r = 0;
    for (i = 63; i >= 0; i--) begin
      r = (r <<< 1) | ((num >>> i) & 64'sd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'sd1 <<< i);
      end
    end
    return q;
  endfunction

  function automatic logic [31:0] ln_entry(input int k);
    longint s;
    longint term;
    int n;
    s = 0;
    if (k == 0) begin
      return 32'd0;
    end
    for (n = 1; n * k <= 62; n++) begin
      term = div_floor(64'sd1 <<< (62 - n * k), longint'(n));
      s = n[0] ? s + term : s - term;
    end
    return 32'((s + (64'sd1 <<< 29)) >>> 30);
  endfunction

  function automatic logic [31:0] atan_entry(input int k);
    longint s;
    longint term;
    int m;
    int n;
    s = 0;
    if (k == 0) begin
      return 32'((PI_Q60 + (64'd1 << 31)) >> 32);
    end
    n = 0;
    for (m = 1; m * k <= 62; m += 2) begin
      term = div_floor(64'sd1 <<< (62 - m * k), longint'(m));
      s = n[0] ? s - term : s + term;
      n++;
    end
    return 32'((s + (64'sd1 <<< 31)) >>> 32);
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    x = v;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv != 64'd0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] gain_q30(input int steps);
    longint p;
    longint f;
    longint s;
    int k;
    int n;
    p = 64'sd1 <<< 31;
    for (k = 0; k < steps; k++) begin
      if (k == 0) begin
        f = 64'sd1 <<< 30;
      end else begin
        s = 0;
        for (n = 0; 2 * k * n <= 62; n++) begin
          s = n[0] ? s - (64'sd1 <<< (62 - 2 * k * n))
                   : s + (64'sd1 <<< (62 - 2 * k * n));
        end
        f = (s + (64'sd1 <<< 30)) >>> 31;
      end
      p = (p * f + (64'sd1 <<< 30)) >>> 31;
    end
    return 32'(isqrt64(64'(p) << 29));
  endfunction

  function automatic logic [31:0] xsh_rr(input logic [63:0] old);
    logic [63:0] mix;
    logic [31:0] x;
    logic [4:0] rot;
    logic [4:0] nrot;
    mix = ((old >> 18) ^ old) >> 27;
    x = mix[31:0];
    rot = old[63:59];
    nrot = 5'd0 - rot;
    return (x >> rot) | (x << nrot);
  endfunction

  function automatic logic [23:0] to_sample(input logic signed [65:0] prod, input int sh);
    longint v;
    v = ($signed(prod[63:0]) + (64'sd1 <<< (sh - 1))) >>> sh;
    if (v > 64'sd8388607) begin
      v = 64'sd8388607;
    end
    if (v < -64'sd8388608) begin
      v = -64'sd8388608;
    end
    return v[23:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gaussian_noise_generator.sv -----
// Top level of the Gaussian noise generator: sequencer and datapath around one multiplier.
`default_nettype none
// A request with the sine half held is answered from the spare: its word passes through
// ST_SPARE and ST_FIN to the output register. A fresh pair takes two generator steps (each
// issues three 32-bit partial products to the multiplier), normalization shifts by eight
// or one, CORDIC_STEPS log steps, the log scale in ST_LNMUL and ST_LNSUB, 32 square root
// steps, the angle states ST_ANG and ST_ANG2, CORDIC_STEPS rotation steps, and ST_MULC,
// ST_MULS, ST_SINR and ST_FIN for the two products and the output word; a restart adds one
// more generator step. The next request is taken in the cycle after the word is loaded.
// The design shares one multiplier and runs the log, root and rotation loops one step at a
// time. The input is stalled while a request is in work, and a finished word waits in
// ST_FIN while the previous word is still stalled at the output.
module gaussian_noise_generator #(
  parameter int FRAC_BITS    = 20,
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [63:0] seed_value_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        restart_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [23:0]      sample_o,
  output logic             from_spare_o
);

  localparam int KW = $clog2(CORDIC_STEPS + 1);
  localparam int AW = $clog2(CORDIC_STEPS);
  localparam int SH = 58 - FRAC_BITS;
  localparam logic signed [33:0] GAIN = $signed({2'b00, gng_pkg::gain_q30(CORDIC_STEPS)});

  logic [31:0]        ln_rom   [CORDIC_STEPS + 1];
  logic signed [33:0] atan_rom [CORDIC_STEPS];

  for (genvar g = 0; g <= CORDIC_STEPS; g++) begin : g_ln
    localparam logic [31:0] V = gng_pkg::ln_entry(g);
    assign ln_rom[g] = V;
  end
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
    localparam logic [31:0] V = gng_pkg::atan_entry(g);
    assign atan_rom[g] = $signed({2'b00, V});
  end

  gng_pkg::state_e st_q, st_d;
  gng_pkg::phase_e ph_q, ph_d;
  logic [63:0] seed_q;
  logic [63:0] lcg_q, lcg_d, inc_q, inc_d, acc_q, acc_d;
  logic [32:0] m_q, m_d;
  logic [5:0] sh_q, sh_d;
  logic [KW-1:0] k_q, k_d;
  logic [4:0] j_q, j_d;
  logic [33:0] t_q, t_d;
  logic [32:0] y_q, y_d;
  logic [63:0] sv_q, sv_d, root_q, root_d;
  logic [31:0] x2_q, x2_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [23:0] res_q, res_d, spare_q, spare_d;
  logic res_flag_q, res_flag_d, spare_vld_q, spare_vld_d;
  logic out_vld_q, out_vld_d;
  logic [23:0] out_smp_q, out_smp_d;
  logic out_flag_q, out_flag_d;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_q;

  logic [33:0] cand;
  logic [63:0] bitv, rb;
  logic signed [33:0] dx, dy, trig_c, trig_s;
  logic signed [39:0] lnp;
  logic [31:0] xsh;

  gng_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_q)
  );

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (st_q != gng_pkg::ST_IDLE);
  assign out_valid_o  = out_vld_q;
  assign sample_o     = out_smp_q;
  assign from_spare_o = out_flag_q;

  assign xsh  = gng_pkg::xsh_rr(lcg_q);
  assign cand = t_q + (t_q >> k_q);
  assign bitv = 64'd1 << {j_q, 1'b0};
  assign rb   = root_q + bitv;
  assign dx   = cy_q >>> k_q;
  assign dy   = cx_q >>> k_q;
  assign lnp  = $signed({2'b00, mul_q[37:0]}) + 40'sd1 - $signed({7'b0, y_q});

  always_comb begin
    unique case (x2_q[31:30])
      2'd0: begin
        trig_c = cx_q;
        trig_s = cy_q;
      end
      2'd1: begin
        trig_c = -cy_q;
        trig_s = cx_q;
      end
      2'd2: begin
        trig_c = -cx_q;
        trig_s = -cy_q;
      end
      default: begin
        trig_c = cy_q;
        trig_s = -cx_q;
      end
    endcase
  end

  always_comb begin
    st_d = st_q;
    ph_d = ph_q;
    lcg_d = lcg_q;
    inc_d = inc_q;
    acc_d = acc_q;
    m_d = m_q;
    sh_d = sh_q;
    k_d = k_q;
    j_d = j_q;
    t_d = t_q;
    y_d = y_q;
    sv_d = sv_q;
    root_d = root_q;
    x2_d = x2_q;
    cx_d = cx_q;
    cy_d = cy_q;
    cz_d = cz_q;
    res_d = res_q;
    res_flag_d = res_flag_q;
    spare_d = spare_q;
    spare_vld_d = spare_vld_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_smp_d = out_smp_q;
    out_flag_d = out_flag_q;
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      gng_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            inc_d = {seed_q[62:0], 1'b1};
            lcg_d = {seed_q[62:0], 1'b1} + (seed_q ^ gng_pkg::GOLDEN);
            spare_vld_d = 1'b0;
            spare_d = '0;
            ph_d = gng_pkg::PH_SEED;
            st_d = gng_pkg::ST_ADV0;
          end else if (spare_vld_q) begin
            st_d = gng_pkg::ST_SPARE;
          end else begin
            ph_d = gng_pkg::PH_X1;
            st_d = gng_pkg::ST_ADV0;
          end
        end
      end
      gng_pkg::ST_SPARE: begin
        res_d = spare_q;
        res_flag_d = 1'b1;
        spare_vld_d = 1'b0;
        st_d = gng_pkg::ST_FIN;
      end
      gng_pkg::ST_ADV0: begin
        if (ph_q == gng_pkg::PH_X1) begin
          m_d = {1'b0, xsh} + 33'd1;
          sh_d = '0;
        end
        if (ph_q == gng_pkg::PH_X2) begin
          x2_d = xsh;
        end
        mul_a = $signed({1'b0, lcg_q[31:0]});
        mul_b = $signed({1'b0, gng_pkg::PCG_MULT[31:0]});
        st_d = gng_pkg::ST_ADV1;
      end
      gng_pkg::ST_ADV1: begin
        acc_d = mul_q[63:0];
        mul_a = $signed({1'b0, lcg_q[31:0]});
        mul_b = $signed({1'b0, gng_pkg::PCG_MULT[63:32]});
        st_d = gng_pkg::ST_ADV2;
      end
      gng_pkg::ST_ADV2: begin
        acc_d = acc_q + {mul_q[31:0], 32'd0};
        mul_a = $signed({1'b0, lcg_q[63:32]});
        mul_b = $signed({1'b0, gng_pkg::PCG_MULT[31:0]});
        st_d = gng_pkg::ST_ADV3;
      end
      gng_pkg::ST_ADV3: begin
        lcg_d = acc_q + {mul_q[31:0], 32'd0} + inc_q;
        unique case (ph_q)
          gng_pkg::PH_SEED: begin
            ph_d = gng_pkg::PH_X1;
            st_d = gng_pkg::ST_ADV0;
          end
          gng_pkg::PH_X1: begin
            ph_d = gng_pkg::PH_X2;
            st_d = gng_pkg::ST_ADV0;
          end
          default: begin
            st_d = gng_pkg::ST_NORM;
          end
        endcase
      end
      gng_pkg::ST_NORM: begin
        if (m_q[32]) begin
          t_d = 34'd1 << 32;
          y_d = '0;
          k_d = KW'(1);
          st_d = gng_pkg::ST_LN;
        end else if (m_q[32:25] == 8'd0) begin
          m_d = m_q << 8;
          sh_d = sh_q + 6'd8;
        end else begin
          m_d = m_q << 1;
          sh_d = sh_q + 6'd1;
        end
      end
      gng_pkg::ST_LN: begin
        if (cand <= {1'b0, m_q}) begin
          t_d = cand;
          y_d = y_q + {1'b0, ln_rom[k_q]};
        end
        if (k_q == KW'(CORDIC_STEPS)) begin
          st_d = gng_pkg::ST_LNMUL;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      gng_pkg::ST_LNMUL: begin
        mul_a = $signed({27'd0, sh_q});
        mul_b = $signed({1'b0, gng_pkg::LN2_Q32});
        st_d = gng_pkg::ST_LNSUB;
      end
      gng_pkg::ST_LNSUB: begin
        sv_d = lnp[39] ? 64'd0 : {lnp[38:0], 25'd0};
        root_d = '0;
        j_d = 5'd31;
        st_d = gng_pkg::ST_SQRT;
      end
      gng_pkg::ST_SQRT: begin
        if (sv_q >= rb) begin
          sv_d = sv_q - rb;
          root_d = (root_q >> 1) + bitv;
        end else begin
          root_d = root_q >> 1;
        end
        if (j_q == 5'd0) begin
          st_d = gng_pkg::ST_ANG;
        end else begin
          j_d = j_q - 5'd1;
        end
      end
      gng_pkg::ST_ANG: begin
        mul_a = $signed({2'b00, x2_q[29:0], 1'b1});
        mul_b = $signed({1'b0, gng_pkg::HALFPI_Q30[31:0]});
        st_d = gng_pkg::ST_ANG2;
      end
      gng_pkg::ST_ANG2: begin
        cz_d = $signed({3'b000, mul_q[61:31]});
        cx_d = GAIN;
        cy_d = '0;
        k_d = '0;
        st_d = gng_pkg::ST_CORD;
      end
      gng_pkg::ST_CORD: begin
        if (!cz_q[33]) begin
          cx_d = cx_q - dx;
          cy_d = cy_q + dy;
          cz_d = cz_q - atan_rom[k_q[AW-1:0]];
        end else begin
          cx_d = cx_q + dx;
          cy_d = cy_q - dy;
          cz_d = cz_q + atan_rom[k_q[AW-1:0]];
        end
        if (k_q == KW'(CORDIC_STEPS - 1)) begin
          st_d = gng_pkg::ST_MULC;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      gng_pkg::ST_MULC: begin
        mul_a = $signed({1'b0, root_q[31:0]});
        mul_b = trig_c[32:0];
        st_d = gng_pkg::ST_MULS;
      end
      gng_pkg::ST_MULS: begin
        res_d = gng_pkg::to_sample(mul_q, SH);
        res_flag_d = 1'b0;
        mul_a = $signed({1'b0, root_q[31:0]});
        mul_b = trig_s[32:0];
        st_d = gng_pkg::ST_SINR;
      end
      gng_pkg::ST_SINR: begin
        spare_d = gng_pkg::to_sample(mul_q, SH);
        spare_vld_d = 1'b1;
        st_d = gng_pkg::ST_FIN;
      end
      gng_pkg::ST_FIN: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_smp_d = res_q;
          out_flag_d = res_flag_q;
          st_d = gng_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = gng_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= gng_pkg::ST_IDLE;
      ph_q <= gng_pkg::PH_SEED;
      seed_q <= '0;
      lcg_q <= gng_pkg::LCG_RESET;
      inc_q <= 64'd1;
      spare_q <= '0;
      spare_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
      if (cfg_valid_i) begin
        seed_q <= seed_value_i;
      end
      lcg_q <= lcg_d;
      inc_q <= inc_d;
      spare_q <= spare_d;
      spare_vld_q <= spare_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    m_q <= m_d;
    sh_q <= sh_d;
    k_q <= k_d;
    j_q <= j_d;
    t_q <= t_d;
    y_q <= y_d;
    sv_q <= sv_d;
    root_q <= root_d;
    x2_q <= x2_d;
    cx_q <= cx_d;
    cy_q <= cy_d;
    cz_q <= cz_d;
    res_q <= res_d;
    res_flag_q <= res_flag_d;
    out_smp_q <= out_smp_d;
    out_flag_q <= out_flag_d;
  end

endmodule
`default_nettype wire

// ----- rtl/gng_mul.sv -----
// Shared signed 33 by 33 multiplier with a registered product.
`default_nettype none
module gng_mul (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [65:0]      p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule
`default_nettype wire
